### rtl/tcw_pkg.sv
//------------------------------------------------------------------------------
// tcw_pkg
// Shared constants and types for the text console writer: default screen size,
// field widths, command codes, newline code, reset attribute, cell layout.
//------------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

	localparam int SCREEN_COLS_DEF = 80;
	localparam int SCREEN_ROWS_DEF = 24;

	localparam int CMD_W        = 1;
	localparam int CHAR_W       = 8;
	localparam int ATTR_W       = 8;
	localparam int READ_ROW_W   = 5;
	localparam int READ_COL_W   = 7;
	localparam int CURSOR_POS_W = 11;

	localparam logic [CMD_W-1:0]  CMD_PUT  = 1'b0;
	localparam logic [CMD_W-1:0]  CMD_READ = 1'b1;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
	localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;

	typedef struct packed {
		logic [ATTR_W-1:0] attr;
		logic [CHAR_W-1:0] chr;
	} cell_t;

	localparam int CELL_W = $bits(cell_t);

endpackage

`default_nettype wire

### rtl/tcw_ram.sv
//------------------------------------------------------------------------------
// tcw_ram
// Generic single-clock RAM: one write port, one read port, registered read.
//------------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
	parameter  int WIDTH  = 16,
	parameter  int DEPTH  = 1920,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### rtl/tcw_map.sv
//------------------------------------------------------------------------------
// tcw_map
// Screen address map: rotates a logical row by the top-row offset of the
// ring buffer and forms the linear buffer address of the cell.
//------------------------------------------------------------------------------
`default_nettype none

module tcw_map #(
	parameter  int SCREEN_COLS = 80,
	parameter  int SCREEN_ROWS = 24,
	localparam int COL_W       = $clog2(SCREEN_COLS),
	localparam int ROW_W       = $clog2(SCREEN_ROWS),
	localparam int ADDR_W      = $clog2(SCREEN_COLS * SCREEN_ROWS)
) (
	input  wire logic [ROW_W-1:0]  row,
	input  wire logic [COL_W-1:0]  col,
	input  wire logic [ROW_W-1:0]  top,
	output logic      [ADDR_W-1:0] addr
);

	logic [ROW_W:0]      row_sum;
	logic [ROW_W-1:0]    phys_row;
	logic [ADDR_W-1:0]   row_base;

	always_comb begin
		row_sum = {1'b0, row} + {1'b0, top};
		if (row_sum >= (ROW_W+1)'(SCREEN_ROWS)) begin
			row_sum = row_sum - (ROW_W+1)'(SCREEN_ROWS);
		end
		phys_row = row_sum[ROW_W-1:0];
		row_base = ADDR_W'(phys_row) * ADDR_W'(SCREEN_COLS);
		addr     = row_base + ADDR_W'(col);
	end

endmodule

`default_nettype wire

### rtl/text_console_writer.sv
//------------------------------------------------------------------------------
// text_console_writer
// Teletype text console over a ring-buffered character-cell screen memory.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+----------------------------------
//   in       | in        | in_valid / in_ready  | cmd, char_code, read_row, read_col
//   out      | out       | out_valid / out_ready| cursor_pos, cell_char, cell_attr,
//            |           |                      | scrolled
//   attr cfg | in        | attr_we              | attr_wdata
//
// A plain put or newline needs no further state; a read passes through the
// READ state (one RAM read). A put that scrolls then wipes a row: the row that
// leaves the top becomes the new bottom row and is zeroed one cell per cycle.
// After reset all SCREEN_COLS*SCREEN_ROWS cells (1920 at default size) are
// zeroed, one per cycle; no item is taken until then.
// A result waits in the output register; a new item is taken once it is free.
//------------------------------------------------------------------------------
`default_nettype none

module text_console_writer
	import tcw_pkg::*;
#(
	parameter int SCREEN_COLS = SCREEN_COLS_DEF,
	parameter int SCREEN_ROWS = SCREEN_ROWS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [CMD_W-1:0]        cmd,
	input  wire logic [CHAR_W-1:0]       char_code,
	input  wire logic [READ_ROW_W-1:0]   read_row,
	input  wire logic [READ_COL_W-1:0]   read_col,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [CURSOR_POS_W-1:0]      cursor_pos,
	output logic [CHAR_W-1:0]            cell_char,
	output logic [ATTR_W-1:0]            cell_attr,
	output logic                         scrolled,
	input  wire logic                    attr_we,
	input  wire logic [ATTR_W-1:0]       attr_wdata
);

	localparam int COL_W     = $clog2(SCREEN_COLS);
	localparam int ROW_W     = $clog2(SCREEN_ROWS);
	localparam int CELLS     = SCREEN_COLS * SCREEN_ROWS;
	localparam int ADDR_W    = $clog2(CELLS);
	localparam int POS_EXT_W = ADDR_W + CURSOR_POS_W;
	localparam int RR_EXT_W  = READ_ROW_W + ROW_W;
	localparam int RC_EXT_W  = READ_COL_W + COL_W;

	localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'((SCREEN_ROWS - 1) * SCREEN_COLS);
	localparam logic [ADDR_W-1:0] LAST_CELL     = ADDR_W'(CELLS - 1);
	localparam logic [COL_W-1:0]  LAST_COL      = COL_W'(SCREEN_COLS - 1);
	localparam logic [ROW_W-1:0]  LAST_ROW      = ROW_W'(SCREEN_ROWS - 1);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_READ  = 2'd2;
	localparam logic [1:0] ST_WIPE  = 2'd3;

	logic [1:0]          state_q;
	logic [ATTR_W-1:0]   attr_q;
	logic [ROW_W-1:0]    cur_row_q;
	logic [COL_W-1:0]    cur_col_q;
	logic [ADDR_W-1:0]   cur_pos_q;
	logic [ROW_W-1:0]    top_q;
	logic [ADDR_W-1:0]   top_base_q;
	logic [ADDR_W-1:0]   clr_addr_q;
	logic [ADDR_W-1:0]   clr_end_q;
	logic                rd_ok_s1;

	logic                out_valid_q;
	logic [CURSOR_POS_W-1:0] out_pos_q;
	logic [CHAR_W-1:0]   out_char_q;
	logic [ATTR_W-1:0]   out_attr_q;
	logic                out_scr_q;

	logic                accept;
	logic                is_put;
	logic                is_nl;
	logic                row_adv;
	logic                do_scroll;
	logic [ROW_W-1:0]    nxt_row;
	logic [COL_W-1:0]    nxt_col;
	logic [ADDR_W-1:0]   nxt_pos;
	logic [POS_EXT_W-1:0] nxt_pos_ext;
	logic [POS_EXT_W-1:0] cur_pos_ext;
	logic                rd_ok;
	logic [RR_EXT_W-1:0] rd_row_ext;
	logic [RC_EXT_W-1:0] rd_col_ext;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	cell_t               ram_wdata;
	logic [ADDR_W-1:0]   ram_raddr;
	cell_t               ram_rdata;
	logic [ADDR_W-1:0]   cur_addr;

	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign is_put   = (cmd == CMD_PUT);
	assign is_nl    = (char_code == NEWLINE_CODE);

	assign rd_row_ext = RR_EXT_W'(read_row);
	assign rd_col_ext = RC_EXT_W'(read_col);
	assign rd_ok      = (32'(read_row) < SCREEN_ROWS) && (32'(read_col) < SCREEN_COLS);

	always_comb begin
		row_adv   = is_nl || (cur_col_q == LAST_COL);
		do_scroll = row_adv && (cur_row_q == LAST_ROW);
		nxt_col   = row_adv ? '0 : cur_col_q + 1'b1;
		nxt_row   = (row_adv && !do_scroll) ? cur_row_q + 1'b1 : cur_row_q;
		if (do_scroll) begin
			nxt_pos = LAST_ROW_BASE;
		end else if (is_nl) begin
			nxt_pos = cur_pos_q + ADDR_W'(SCREEN_COLS) - ADDR_W'(cur_col_q);
		end else begin
			nxt_pos = cur_pos_q + 1'b1;
		end
		nxt_pos_ext = POS_EXT_W'(nxt_pos);
		cur_pos_ext = POS_EXT_W'(cur_pos_q);
	end

	tcw_map #(
		.SCREEN_COLS(SCREEN_COLS),
		.SCREEN_ROWS(SCREEN_ROWS)
	) u_cur_map (
		.row (cur_row_q),
		.col (cur_col_q),
		.top (top_q),
		.addr(cur_addr)
	);

	tcw_map #(
		.SCREEN_COLS(SCREEN_COLS),
		.SCREEN_ROWS(SCREEN_ROWS)
	) u_rd_map (
		.row (rd_row_ext[ROW_W-1:0]),
		.col (rd_col_ext[COL_W-1:0]),
		.top (top_q),
		.addr(ram_raddr)
	);

	always_comb begin
		if (state_q == ST_CLEAR || state_q == ST_WIPE) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we         = accept && is_put && !is_nl;
			ram_waddr      = cur_addr;
			ram_wdata.attr = attr_q;
			ram_wdata.chr  = char_code;
		end
	end

	tcw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_screen_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (attr_we) begin
			attr_q <= attr_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			cur_row_q  <= '0;
			cur_col_q  <= '0;
			cur_pos_q  <= '0;
			top_q      <= '0;
			top_base_q <= '0;
			clr_addr_q <= '0;
			clr_end_q  <= LAST_CELL;
		end else begin
			unique case (state_q)
				ST_CLEAR, ST_WIPE: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == clr_end_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (is_put) begin
							cur_row_q <= nxt_row;
							cur_col_q <= nxt_col;
							cur_pos_q <= nxt_pos;
							if (do_scroll) begin
								state_q    <= ST_WIPE;
								clr_addr_q <= top_base_q;
								clr_end_q  <= top_base_q + ADDR_W'(LAST_COL);
								if (top_q == LAST_ROW) begin
									top_q      <= '0;
									top_base_q <= '0;
								end else begin
									top_q      <= top_q + 1'b1;
									top_base_q <= top_base_q + ADDR_W'(SCREEN_COLS);
								end
							end
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((accept && is_put) || state_q == ST_READ) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_ok_s1 <= rd_ok;
		end
		if (accept && is_put) begin
			out_pos_q  <= nxt_pos_ext[CURSOR_POS_W-1:0];
			out_char_q <= '0;
			out_attr_q <= '0;
			out_scr_q  <= do_scroll;
		end else if (state_q == ST_READ) begin
			out_pos_q  <= cur_pos_ext[CURSOR_POS_W-1:0];
			out_char_q <= rd_ok_s1 ? ram_rdata.chr : '0;
			out_attr_q <= rd_ok_s1 ? ram_rdata.attr : '0;
			out_scr_q  <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign cursor_pos = out_pos_q;
	assign cell_char  = out_char_q;
	assign cell_attr  = out_attr_q;
	assign scrolled   = out_scr_q;

endmodule

`default_nettype wire

### rtl/tcw_checker.sv
//------------------------------------------------------------------------------
// tcw_checker
// Port-level checks for the text console writer, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none

module tcw_checker
	import tcw_pkg::*;
#(
	parameter int SCREEN_COLS = SCREEN_COLS_DEF,
	parameter int SCREEN_ROWS = SCREEN_ROWS_DEF
) (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    in_valid,
	input wire logic                    in_ready,
	input wire logic [CMD_W-1:0]        cmd,
	input wire logic                    out_valid,
	input wire logic                    out_ready,
	input wire logic [CURSOR_POS_W-1:0] cursor_pos,
	input wire logic [CHAR_W-1:0]       cell_char,
	input wire logic [ATTR_W-1:0]       cell_attr,
	input wire logic                    scrolled
);

	localparam int POS_EXT_W = 32 + CURSOR_POS_W;
	localparam logic [POS_EXT_W-1:0] LAST_BASE_EXT =
		POS_EXT_W'((SCREEN_ROWS - 1) * SCREEN_COLS);
	localparam logic [CURSOR_POS_W-1:0] LAST_BASE = LAST_BASE_EXT[CURSOR_POS_W-1:0];

	a_ready_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!out_valid || out_ready))
		else $error("item taken while a result is blocked");

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && cmd == CMD_READ) |=> !in_ready)
		else $error("read item did not hold off the next item");

	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && scrolled) |-> (cursor_pos == LAST_BASE))
		else $error("scroll left cursor off the bottom row start");

	a_scroll_no_cell: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && scrolled) |-> (cell_char == '0 && cell_attr == '0))
		else $error("scrolled put carries cell data");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(cursor_pos) && $stable(scrolled)))
		else $error("stalled result changed");

endmodule

bind text_console_writer tcw_checker #(
	.SCREEN_COLS(SCREEN_COLS),
	.SCREEN_ROWS(SCREEN_ROWS)
) u_tcw_checker (.*);

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb
// Self-checking bench for text_console_writer. A short directed table walks
// the corner cases: reads at and past the screen edges, the extreme character
// bytes, newline, a newline on the bottom row and a put into the last cell,
// both of which scroll. Then random put and read items run under several text
// attributes. The extremes 0x00 and 0xFF are among them. A shadow screen and
// cursor in the bench predict every result that the table does not give, and
// the results are compared field by field in order. Both handshakes stall in
// short random bursts, except in the final phase.
//------------------------------------------------------------------------------

module tb;
	import tcw_pkg::*;

	localparam int COLS  = SCREEN_COLS_DEF;
	localparam int ROWS  = SCREEN_ROWS_DEF;
	localparam int CELLS = COLS * ROWS;
	localparam int RANDOM_ITEMS = 380;
	localparam int PHASES = 4;

	typedef struct {
		logic [CMD_W-1:0]      cmd;
		logic [CHAR_W-1:0]     chr;
		logic [READ_ROW_W-1:0] row;
		logic [READ_COL_W-1:0] col;
	} console_item_t;

	typedef struct packed {
		logic [CURSOR_POS_W-1:0] cursor;
		logic [CHAR_W-1:0]       chr;
		logic [ATTR_W-1:0]       attr;
		logic                    scrolled;
	} console_result_t;

	typedef struct {
		console_item_t   item;
		int              reps;
		bit              typed;
		console_result_t want;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [CMD_W-1:0] cmd = CMD_PUT;
	logic [CHAR_W-1:0] char_code = '0;
	logic [READ_ROW_W-1:0] read_row = '0;
	logic [READ_COL_W-1:0] read_col = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [CURSOR_POS_W-1:0] cursor_pos;
	logic [CHAR_W-1:0] cell_char;
	logic [ATTR_W-1:0] cell_attr;
	logic scrolled;
	logic attr_we = 1'b0;
	logic [ATTR_W-1:0] attr_wdata = '0;

	cell_t             shadow_screen [CELLS];
	int unsigned       shadow_cursor;
	logic [ATTR_W-1:0] shadow_attr;

	console_result_t pending_results [$];
	script_row_t     script [$];
	bit              quiet = 1'b0;
	int              errors = 0;
	int              n_items = 0;
	int              n_reads = 0;
	int              n_scrolls = 0;
	int              n_results = 0;

	text_console_writer u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.char_code  (char_code),
		.read_row   (read_row),
		.read_col   (read_col),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cursor_pos (cursor_pos),
		.cell_char  (cell_char),
		.cell_attr  (cell_attr),
		.scrolled   (scrolled),
		.attr_we    (attr_we),
		.attr_wdata (attr_wdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic console_result_t console_step(console_item_t it);
		console_result_t r;
		int unsigned     idx;
		r = '0;
		if (it.cmd == CMD_PUT) begin
			if (it.chr == NEWLINE_CODE) begin
				shadow_cursor += COLS - shadow_cursor % COLS;
			end else begin
				shadow_screen[shadow_cursor] = '{attr: shadow_attr, chr: it.chr};
				shadow_cursor++;
			end
			if (shadow_cursor >= CELLS) begin
				for (idx = 0; idx < CELLS - COLS; idx++)
					shadow_screen[idx] = shadow_screen[idx + COLS];
				for (idx = CELLS - COLS; idx < CELLS; idx++)
					shadow_screen[idx] = '0;
				shadow_cursor -= COLS;
				r.scrolled = 1'b1;
			end
		end else if (it.row < ROWS && it.col < COLS) begin
			r.chr  = shadow_screen[it.row * COLS + it.col].chr;
			r.attr = shadow_screen[it.row * COLS + it.col].attr;
		end
		r.cursor = shadow_cursor[CURSOR_POS_W-1:0];
		return r;
	endfunction

	task automatic add_row(input logic [CMD_W-1:0] c, input logic [CHAR_W-1:0] ch,
			input int rw, input int cl, input int reps, input bit typed,
			input int w_cur, input int w_chr, input int w_attr, input bit w_scr);
		script_row_t s;
		s.item  = '{cmd: c, chr: ch, row: rw[READ_ROW_W-1:0], col: cl[READ_COL_W-1:0]};
		s.reps  = reps;
		s.typed = typed;
		s.want  = '{cursor: w_cur[CURSOR_POS_W-1:0], chr: w_chr[CHAR_W-1:0],
			attr: w_attr[ATTR_W-1:0], scrolled: w_scr};
		script.push_back(s);
	endtask

	function automatic console_item_t random_item();
		console_item_t it;
		int            k;
		k = $urandom_range(0, 99);
		it.row = READ_ROW_W'($urandom_range(0, 31));
		it.col = READ_COL_W'($urandom_range(0, 127));
		if (k < 30) begin
			it.cmd = CMD_READ;
			it.chr = CHAR_W'($urandom_range(0, 255));
			if (k < 27) begin
				it.row = READ_ROW_W'($urandom_range(0, ROWS - 1));
				it.col = READ_COL_W'($urandom_range(0, COLS - 1));
			end
		end else begin
			it.cmd = CMD_PUT;
			it.chr = (k < 42) ? NEWLINE_CODE : CHAR_W'($urandom_range(0, 255));
		end
		return it;
	endfunction

	task automatic send_item(input console_item_t it, input bit typed,
			input console_result_t want);
		console_result_t predicted;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		cmd       <= it.cmd;
		char_code <= it.chr;
		read_row  <= it.row;
		read_col  <= it.col;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted = console_step(it);
		pending_results.push_back(typed ? want : predicted);
		n_items++;
		if (it.cmd == CMD_READ)
			n_reads++;
		if (predicted.scrolled)
			n_scrolls++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic set_attribute(input logic [ATTR_W-1:0] value);
		attr_we    <= 1'b1;
		attr_wdata <= value;
		@(posedge clk);
		attr_we    <= 1'b0;
		shadow_attr = value;
	endtask

	// Stall the result side in short bursts.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		console_result_t want;
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (pending_results.size() == 0) begin
				$error("unexpected result: cursor_pos %0d", cursor_pos);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (cursor_pos !== want.cursor) begin
					$error("cursor_pos: expected %0d, got %0d", want.cursor, cursor_pos);
					errors++;
				end
				if (cell_char !== want.chr) begin
					$error("cell_char: expected %0h, got %0h", want.chr, cell_char);
					errors++;
				end
				if (cell_attr !== want.attr) begin
					$error("cell_attr: expected %0h, got %0h", want.attr, cell_attr);
					errors++;
				end
				if (scrolled !== want.scrolled) begin
					$error("scrolled: expected %0b, got %0b", want.scrolled, scrolled);
					errors++;
				end
			end
		end
	end

	initial begin
		console_result_t none;
		int              rep;
		int              ph;
		int              n;
		logic [ATTR_W-1:0] phase_attr;

		none = '0;
		foreach (shadow_screen[i])
			shadow_screen[i] = '0;
		shadow_cursor = 0;
		shadow_attr   = ATTR_RESET;

		// Reads at and past the edges of a blank screen.
		add_row(CMD_READ, 8'h00, 0, 0, 1, 1, 0, 0, 0, 0);
		add_row(CMD_READ, 8'hFF, 31, 127, 1, 1, 0, 0, 0, 0);
		add_row(CMD_READ, 8'h00, ROWS - 1, COLS - 1, 1, 1, 0, 0, 0, 0);
		add_row(CMD_READ, 8'h00, 5, COLS, 1, 1, 0, 0, 0, 0);
		add_row(CMD_READ, 8'h00, ROWS, 0, 1, 1, 0, 0, 0, 0);
		// Extreme character bytes, then newline; read them back, then two more puts.
		add_row(CMD_PUT, 8'h00, 31, 127, 1, 1, 1, 0, 0, 0);
		add_row(CMD_PUT, 8'hFF, 0, 0, 1, 1, 2, 0, 0, 0);
		add_row(CMD_PUT, NEWLINE_CODE, 0, 0, 1, 1, COLS, 0, 0, 0);
		add_row(CMD_READ, 8'h00, 0, 1, 1, 1, COLS, 8'hFF, ATTR_RESET, 0);
		add_row(CMD_READ, 8'h00, 0, 0, 1, 1, COLS, 8'h00, ATTR_RESET, 0);
		add_row(CMD_PUT, 8'h0B, 0, 0, 1, 0, 0, 0, 0, 0);
		add_row(CMD_PUT, 8'h8A, 0, 0, 1, 0, 0, 0, 0, 0);
		// Walk down to the bottom row, then newline there.
		add_row(CMD_PUT, NEWLINE_CODE, 0, 0, ROWS - 2, 0, 0, 0, 0, 0);
		add_row(CMD_PUT, NEWLINE_CODE, 0, 0, 1, 1, CELLS - COLS, 0, 0, 1);
		// Fill the bottom row, then put into the last cell.
		add_row(CMD_PUT, 8'h41, 0, 0, COLS - 1, 0, 0, 0, 0, 0);
		add_row(CMD_PUT, 8'h5A, 0, 0, 1, 1, CELLS - COLS, 0, 0, 1);
		add_row(CMD_READ, 8'h00, ROWS - 2, COLS - 1, 1, 1, CELLS - COLS, 8'h5A,
			ATTR_RESET, 0);
		add_row(CMD_READ, 8'h00, ROWS - 1, COLS - 1, 1, 1, CELLS - COLS, 0, 0, 0);
		add_row(CMD_READ, 8'h00, ROWS - 2, 0, 1, 0, 0, 0, 0, 0);
		add_row(CMD_READ, 8'h00, 0, 0, 1, 0, 0, 0, 0, 0);
		add_row(CMD_READ, 8'h00, 1, 1, 1, 0, 0, 0, 0, 0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (script[i])
			for (rep = 0; rep < script[i].reps; rep++)
				send_item(script[i].item, script[i].typed && rep == script[i].reps - 1,
					script[i].typed ? script[i].want : none);
		drain();

		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: phase_attr = 8'h00;
				1: phase_attr = 8'hFF;
				default: phase_attr = ATTR_W'($urandom_range(1, 254));
			endcase
			set_attribute(phase_attr);
			if (ph == PHASES - 1)
				quiet = 1'b1;
			for (n = 0; n < RANDOM_ITEMS / PHASES; n++)
				send_item(random_item(), 1'b0, none);
			drain();
		end

		repeat (COLS + 8) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			errors++;
		end
		$display("Ran %0d items (%0d reads, %0d scrolls), %0d results checked",
			n_items, n_reads, n_scrolls, n_results);
		$display("Attribute settings: reset value plus %0d written, 0x00 and 0xFF included",
			PHASES);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### files.f
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_map.sv
rtl/text_console_writer.sv
rtl/tcw_checker.sv
tb/tb.sv
